@@ rtl/pcsbd_pkg.sv @@
package pcsbd_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        CFG_DECIM_RATIO      = 2'd0,
        CFG_ENCODER_CHANNELS = 2'd1,
        CFG_CAPTURE_CHANNELS = 2'd2,
        CFG_SELECTED_CHANNEL = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_SETUP = 2'd1,
        STATUS_BAD_BLOCK = 2'd2
    } status_t;

    localparam int SAMPLE_W   = 16;
    localparam int OUT_CH_W   = 3;
    localparam int RATIO_W    = 7;
    localparam int CHANS_W    = 4;
    localparam int SEL_W      = 3;
    localparam int CFG_DATA_W = 8;
    localparam int M_TDATA_W  = 24;
    localparam int CMP_W      = 9;

    localparam logic [SAMPLE_W-1:0] SAT_POS = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] SAT_NEG = 16'h8000;

endpackage

@@ rtl/pcm_channel_select_box_decimator.sv @@
// Channel | Dir | Handshake           | Payload
// s_      | in  | s_tvalid / s_tready | s_tdata pcm_sample, s_tlast block_end
// m_      | out | m_tvalid / m_tready | m_tdata avg_sample+out_channel, m_tuser status,
//         |     |                     | m_tlast last_of_block
// cfg_    | in  | cfg_valid/cfg_ready | cfg_index register, cfg_data value
//
// An item that gives no result leaves the block idle for the next one. An error result
// at block end skips the divider; an averaged result first runs through the restoring
// divider, one quotient bit per cycle. No new item is taken before the result is loaded.
// aresetn is synchronous, active low, clears sums, counters and m_tvalid, and sets the
// setup to its defaults. A stalled result waits in the output register; the next item
// may be taken meanwhile, but its own result waits for that register to drain.
module pcm_channel_select_box_decimator #(
    parameter int MAX_CHANNELS = 8,
    parameter int MAX_RATIO    = 64
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [pcsbd_pkg::SAMPLE_W-1:0]        s_tdata,   // [15:0] pcm_sample
    input  logic                                  s_tlast,

    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [pcsbd_pkg::M_TDATA_W-1:0]       m_tdata,   // [15:0] avg_sample,
                                                             // [18:16] out_channel
    output logic [1:0]                            m_tuser,   // [1:0] status
    output logic                                  m_tlast,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [1:0]                            cfg_index,
    input  logic [pcsbd_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int POS_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int PH_W  = (MAX_RATIO > 1) ? $clog2(MAX_RATIO) : 1;
    localparam int SUM_W = pcsbd_pkg::SAMPLE_W + PH_W;
    localparam int CNT_W = $clog2(SUM_W);
    localparam int REM_W = pcsbd_pkg::RATIO_W;
    localparam int CMP_W = pcsbd_pkg::CMP_W;

    pcsbd_pkg::state_t state_reg, state_next;

    logic [pcsbd_pkg::RATIO_W-1:0] ratio_reg, ratio_next;
    logic [pcsbd_pkg::CHANS_W-1:0] enc_reg, enc_next;
    logic [pcsbd_pkg::CHANS_W-1:0] cap_reg, cap_next;
    logic [pcsbd_pkg::SEL_W-1:0]   sel_reg, sel_next;

    logic signed [SUM_W-1:0] sums_reg [MAX_CHANNELS];
    logic signed [SUM_W-1:0] sums_next [MAX_CHANNELS];
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [PH_W-1:0]         phase_reg, phase_next;

    logic [SUM_W-1:0]              quo_reg, quo_next;
    logic [REM_W-1:0]              rem_reg, rem_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic                          neg_reg, neg_next;
    logic [pcsbd_pkg::OUT_CH_W-1:0] ch_reg, ch_next;
    logic                          last_reg, last_next;
    pcsbd_pkg::status_t            status_reg, status_next;

    logic                             m_tvalid_reg, m_tvalid_next;
    logic [pcsbd_pkg::M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [1:0]                       m_tuser_reg, m_tuser_next;
    logic                             m_tlast_reg, m_tlast_next;

    logic in_acc;
    logic load_out;
    logic ratio_ok, cap_ok, run_ok, mono, map_ok;
    logic frame_last, group_last, aligned, pos_in_range;
    logic do_add, emit, end_err;
    logic [POS_W-1:0] idx;
    logic signed [SUM_W-1:0] sample_ext, new_sum, div_sum;
    pcsbd_pkg::status_t end_status;
    logic [REM_W:0] trial;
    logic [REM_W:0] trial_diff;
    logic [pcsbd_pkg::SAMPLE_W-1:0] avg_val;

    // Decode the setup and the position of the sample in its frame and run
    always_comb begin
        ratio_ok     = (ratio_reg != '0) && (CMP_W'(ratio_reg) <= CMP_W'(MAX_RATIO));
        cap_ok       = (cap_reg != '0) && (CMP_W'(cap_reg) <= CMP_W'(MAX_CHANNELS));
        run_ok       = ratio_ok && cap_ok;
        mono         = (enc_reg == pcsbd_pkg::CHANS_W'(1));
        map_ok       = mono ? (CMP_W'(sel_reg) < CMP_W'(cap_reg)) : (enc_reg == cap_reg);
        frame_last   = (CMP_W'(pos_reg) + CMP_W'(1)) >= CMP_W'(cap_reg);
        group_last   = (CMP_W'(phase_reg) + CMP_W'(1)) >= CMP_W'(ratio_reg);
        aligned      = run_ok && frame_last && group_last;
        pos_in_range = CMP_W'(pos_reg) < CMP_W'(MAX_CHANNELS);
        idx          = mono ? '0 : pos_reg;
        sample_ext   = {{(SUM_W - pcsbd_pkg::SAMPLE_W){s_tdata[pcsbd_pkg::SAMPLE_W-1]}},
                        s_tdata};
        new_sum      = sums_reg[idx] + sample_ext;
        do_add       = run_ok && map_ok &&
                       (mono ? (CMP_W'(pos_reg) == CMP_W'(sel_reg)) : pos_in_range);
        div_sum      = do_add ? new_sum : sums_reg[idx];
        emit         = run_ok && map_ok && (mono ? aligned : (pos_in_range && group_last));

        if (!ratio_ok) begin
            end_status = pcsbd_pkg::STATUS_BAD_BLOCK;
        end else if (!cap_ok) begin
            end_status = pcsbd_pkg::STATUS_BAD_SETUP;
        end else if (!aligned) begin
            end_status = pcsbd_pkg::STATUS_BAD_BLOCK;
        end else if (!map_ok) begin
            end_status = pcsbd_pkg::STATUS_BAD_SETUP;
        end else if (!emit) begin
            end_status = pcsbd_pkg::STATUS_BAD_BLOCK;
        end else begin
            end_status = pcsbd_pkg::STATUS_OK;
        end
        end_err = s_tlast && (end_status != pcsbd_pkg::STATUS_OK);
    end

    // Handshake control
    always_comb begin
        s_tready  = (state_reg == pcsbd_pkg::ST_IDLE);
        cfg_ready = 1'b1;
        in_acc    = s_tvalid && s_tready;
        load_out  = (state_reg == pcsbd_pkg::ST_OUT) && (!m_tvalid_reg || m_tready);
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pcsbd_pkg::ST_IDLE: begin
                if (in_acc && end_err) begin
                    state_next = pcsbd_pkg::ST_OUT;
                end else if (in_acc && emit) begin
                    state_next = pcsbd_pkg::ST_DIV;
                end
            end
            pcsbd_pkg::ST_DIV: begin
                if (cnt_reg == CNT_W'(SUM_W - 1)) begin
                    state_next = pcsbd_pkg::ST_OUT;
                end
            end
            pcsbd_pkg::ST_OUT: begin
                if (load_out) begin
                    state_next = pcsbd_pkg::ST_IDLE;
                end
            end
            default: state_next = pcsbd_pkg::ST_IDLE;
        endcase
    end

    // Configuration, sums, counters and the shared divider
    always_comb begin
        ratio_next  = ratio_reg;
        enc_next    = enc_reg;
        cap_next    = cap_reg;
        sel_next    = sel_reg;
        sums_next   = sums_reg;
        pos_next    = pos_reg;
        phase_next  = phase_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        neg_next    = neg_reg;
        ch_next     = ch_reg;
        last_next   = last_reg;
        status_next = status_reg;

        trial      = {rem_reg, quo_reg[SUM_W-1]};
        trial_diff = trial - (REM_W + 1)'(ratio_reg);

        if (cfg_valid && cfg_ready) begin
            case (pcsbd_pkg::cfg_index_t'(cfg_index))
                pcsbd_pkg::CFG_DECIM_RATIO:
                    ratio_next = cfg_data[pcsbd_pkg::RATIO_W-1:0];
                pcsbd_pkg::CFG_ENCODER_CHANNELS:
                    enc_next = cfg_data[pcsbd_pkg::CHANS_W-1:0];
                pcsbd_pkg::CFG_CAPTURE_CHANNELS:
                    cap_next = cfg_data[pcsbd_pkg::CHANS_W-1:0];
                pcsbd_pkg::CFG_SELECTED_CHANNEL:
                    sel_next = cfg_data[pcsbd_pkg::SEL_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            pcsbd_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (run_ok) begin
                        if (frame_last) begin
                            pos_next   = '0;
                            phase_next = group_last ? '0 : phase_reg + PH_W'(1);
                        end else begin
                            pos_next = pos_reg + POS_W'(1);
                        end
                    end
                    if (emit) begin
                        sums_next[idx] = '0;
                    end else if (do_add) begin
                        sums_next[idx] = new_sum;
                    end
                    quo_next    = div_sum[SUM_W-1] ? (SUM_W'(0) - div_sum) : div_sum;
                    neg_next    = div_sum[SUM_W-1];
                    rem_next    = '0;
                    cnt_next    = '0;
                    ch_next     = mono ? '0 : pcsbd_pkg::OUT_CH_W'(pos_reg);
                    last_next   = s_tlast;
                    status_next = pcsbd_pkg::STATUS_OK;
                    if (s_tlast) begin
                        for (int i = 0; i < MAX_CHANNELS; i++) begin
                            sums_next[i] = '0;
                        end
                        pos_next    = '0;
                        phase_next  = '0;
                        status_next = end_status;
                        if (end_err) begin
                            quo_next = '0;
                            neg_next = 1'b0;
                            ch_next  = '0;
                        end
                    end
                end
            end
            pcsbd_pkg::ST_DIV: begin
                if (!trial_diff[REM_W]) begin
                    rem_next = trial_diff[REM_W-1:0];
                    quo_next = {quo_reg[SUM_W-2:0], 1'b1};
                end else begin
                    rem_next = trial[REM_W-1:0];
                    quo_next = {quo_reg[SUM_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + CNT_W'(1);
            end
            default: ;
        endcase
    end

    // Saturate the quotient and drive the output register
    always_comb begin
        if (!neg_reg) begin
            avg_val = (quo_reg > SUM_W'(pcsbd_pkg::SAT_POS)) ? pcsbd_pkg::SAT_POS
                                                              : quo_reg[15:0];
        end else begin
            avg_val = (quo_reg > SUM_W'(pcsbd_pkg::SAT_NEG)) ? pcsbd_pkg::SAT_NEG
                                                              : (16'd0 - quo_reg[15:0]);
        end

        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        if (load_out) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {5'd0, ch_reg, avg_val};
            m_tuser_next  = status_reg;
            m_tlast_next  = last_reg;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pcsbd_pkg::ST_IDLE;
            ratio_reg    <= pcsbd_pkg::RATIO_W'(1);
            enc_reg      <= pcsbd_pkg::CHANS_W'(1);
            cap_reg      <= pcsbd_pkg::CHANS_W'(1);
            sel_reg      <= '0;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                sums_reg[i] <= '0;
            end
            pos_reg      <= '0;
            phase_reg    <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ratio_reg    <= ratio_next;
            enc_reg      <= enc_next;
            cap_reg      <= cap_next;
            sel_reg      <= sel_next;
            sums_reg     <= sums_next;
            pos_reg      <= pos_next;
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        neg_reg     <= neg_next;
        ch_reg      <= ch_next;
        last_reg    <= last_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
